// ===== design/hcal_pkg.sv =====
// ----------------------------------------------------------------------------
// hcal_pkg
// Shared types, constants and register map for the humidity/temperature
// calibration block.
// ----------------------------------------------------------------------------
package hcal_pkg;

  localparam int HUM_DIGITS  = 1;
  localparam int TEMP_DIGITS = 1;

  function automatic int pow10(input int digits);
    int p;
    p = 1;
    for (int i = 0; i < 6; i++) begin
      if (i < digits) begin
        p = p * 10;
      end
    end
    return p;
  endfunction

  localparam int HUM_SCALE  = pow10(HUM_DIGITS);
  localparam int TEMP_SCALE = pow10(TEMP_DIGITS);
  localparam int MAX_SCALE  = (HUM_SCALE > TEMP_SCALE) ? HUM_SCALE : TEMP_SCALE;
  localparam int HUM_TOP    = 100 * HUM_SCALE;

  // interpolation numerator before scaling stays inside +/- 2^27
  localparam int BASE_W    = 28;
  localparam int NUM_MAG_W = BASE_W - 1 + $clog2(MAX_SCALE);
  localparam int DIV_W     = 19;
  localparam int CNT_W     = $clog2(NUM_MAG_W + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic ACT_HUM  = 1'b0;
  localparam logic ACT_TEMP = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CLAMP = 2'd1;
  localparam logic [1:0] STATUS_ZERO  = 2'd2;

  localparam logic [2:0] REG_TEMP_CAL_LOW  = 3'd0;
  localparam logic [2:0] REG_TEMP_CAL_HIGH = 3'd1;
  localparam logic [2:0] REG_TEMP_RAW_LOW  = 3'd2;
  localparam logic [2:0] REG_TEMP_RAW_HIGH = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_LOW   = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_HIGH  = 3'd5;
  localparam logic [2:0] REG_HUM_RAW_LOW   = 3'd6;
  localparam logic [2:0] REG_HUM_RAW_HIGH  = 3'd7;

  typedef struct packed {
    logic               action;
    logic signed [15:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] scaled_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [9:0]         temp_cal_low_x8;
    logic [9:0]         temp_cal_high_x8;
    logic signed [15:0] temp_raw_low;
    logic signed [15:0] temp_raw_high;
    logic [7:0]         hum_cal_low_x2;
    logic [7:0]         hum_cal_high_x2;
    logic signed [15:0] hum_raw_low;
    logic signed [15:0] hum_raw_high;
  } hcal_cfg_t;

  typedef struct packed {
    logic                 action;
    logic                 zero;
    logic                 neg;
    logic [NUM_MAG_W-1:0] num_mag;
    logic [DIV_W-1:0]     div_mag;
  } hcal_job_t;

endpackage

// ===== design/hcal_front.sv =====
// ----------------------------------------------------------------------------
// hcal_front
// Accepts samples, selects the calibration set and forms the scaled
// numerator and divisor magnitudes over three stalling stages.
// ----------------------------------------------------------------------------
module hcal_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcal_pkg::in_item_t  in_data,
  input  hcal_pkg::hcal_cfg_t cfg,
  output logic                job_valid,
  input  logic                job_ready,
  output hcal_pkg::hcal_job_t job
);
  import hcal_pkg::*;

  logic advance;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_action_r;
  logic signed [16:0] s1_dx_r;
  logic signed [10:0] s1_dc_r;
  logic [9:0]         s1_c0_r;
  logic signed [16:0] s1_span_r;

  logic               s2_valid_r, s2_valid_nxt;
  logic               s2_action_r;
  logic signed [16:0] s2_span_r;
  logic signed [BASE_W-1:0] s2_p1_r;
  logic signed [BASE_W-1:0] s2_p2_r;

  logic      s3_valid_r, s3_valid_nxt;
  hcal_job_t s3_job_r;

  logic signed [15:0] sel_r0;
  logic signed [15:0] sel_r1;
  logic [9:0]         sel_c0;
  logic [9:0]         sel_c1;
  logic signed [16:0] dx;
  logic signed [16:0] span;
  logic signed [10:0] dc;

  logic signed [BASE_W-1:0]  num;
  logic signed [NUM_MAG_W:0] num_ext;
  logic signed [NUM_MAG_W:0] scale;
  logic signed [NUM_MAG_W:0] scaled;
  logic signed [NUM_MAG_W:0] scaled_abs;
  logic [16:0]               span_abs;
  hcal_job_t                 job_nxt;

  assign advance  = !s3_valid_r || job_ready;
  assign in_ready = advance;

  always_comb begin
    if (in_data.action == ACT_TEMP) begin
      sel_r0 = cfg.temp_raw_low;
      sel_r1 = cfg.temp_raw_high;
      sel_c0 = cfg.temp_cal_low_x8;
      sel_c1 = cfg.temp_cal_high_x8;
    end else begin
      sel_r0 = cfg.hum_raw_low;
      sel_r1 = cfg.hum_raw_high;
      sel_c0 = {2'b00, cfg.hum_cal_low_x2};
      sel_c1 = {2'b00, cfg.hum_cal_high_x2};
    end
    dx   = 17'(in_data.raw_sample) - 17'(sel_r0);
    span = 17'(sel_r1) - 17'(sel_r0);
    dc   = $signed({1'b0, sel_c1}) - $signed({1'b0, sel_c0});
  end

  assign s1_valid_nxt = advance ? (in_valid && in_ready) : s1_valid_r;
  assign s2_valid_nxt = advance ? s1_valid_r : s2_valid_r;
  assign s3_valid_nxt = advance ? s2_valid_r : s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_comb begin
    num        = s2_p1_r + s2_p2_r;
    num_ext    = (NUM_MAG_W + 1)'(num);
    scale      = (s2_action_r == ACT_TEMP) ? (NUM_MAG_W + 1)'(TEMP_SCALE)
                                           : (NUM_MAG_W + 1)'(HUM_SCALE);
    scaled     = num_ext * scale;
    scaled_abs = scaled[NUM_MAG_W] ? -scaled : scaled;
    span_abs   = s2_span_r[16] ? 17'(-s2_span_r) : 17'(s2_span_r);

    job_nxt.action  = s2_action_r;
    job_nxt.zero    = (s2_span_r == '0);
    job_nxt.neg     = scaled[NUM_MAG_W] ^ s2_span_r[16];
    job_nxt.num_mag = scaled_abs[NUM_MAG_W-1:0];
    if (s2_action_r == ACT_TEMP) begin
      job_nxt.div_mag = {span_abs[15:0], 3'b000};
    end else begin
      job_nxt.div_mag = {2'b00, span_abs[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_action_r <= in_data.action;
      s1_dx_r     <= dx;
      s1_dc_r     <= dc;
      s1_c0_r     <= sel_c0;
      s1_span_r   <= span;

      s2_action_r <= s1_action_r;
      s2_span_r   <= s1_span_r;
      s2_p1_r     <= BASE_W'(s1_dx_r * s1_dc_r);
      s2_p2_r     <= BASE_W'($signed({1'b0, s1_c0_r}) * s1_span_r);

      s3_job_r    <= job_nxt;
    end
  end

  assign job_valid = s3_valid_r;
  assign job       = s3_job_r;

endmodule

// ===== design/hcal_fifo.sv =====
// ----------------------------------------------------------------------------
// hcal_fifo
// Short job queue that decouples the front stages from the divider.
// ----------------------------------------------------------------------------
module hcal_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  hcal_pkg::hcal_job_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output hcal_pkg::hcal_job_t rd_data
);
  import hcal_pkg::*;

  hcal_job_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  push;
  logic                  pop;

  assign wr_ready = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/hcal_back.sv =====
// ----------------------------------------------------------------------------
// hcal_back
// Radix-2 restoring divider, then clamp or saturate and hold the result
// in the output register.
// ----------------------------------------------------------------------------
module hcal_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  hcal_pkg::hcal_job_t  job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hcal_pkg::out_item_t  out_data
);
  import hcal_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [NUM_MAG_W-1:0] quo_r, quo_nxt;
  logic                 act_r, neg_r, zero_r;
  logic [DIV_W-1:0]     div_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [DIV_W:0] trial;
  logic           fits;
  logic           finish;
  logic           take;
  out_item_t      res;

  assign job_ready = !busy_r;
  assign take      = job_valid && job_ready;
  assign finish    = busy_r && (cnt_r == '0) && (!out_valid_r || out_ready);

  assign trial = {rem_r, quo_r[NUM_MAG_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    res.scaled_value = '0;
    res.status       = STATUS_OK;
    if (zero_r) begin
      res.status = STATUS_ZERO;
    end else if (act_r == ACT_HUM) begin
      if (neg_r && (quo_r != '0)) begin
        res.status = STATUS_CLAMP;
      end else if (quo_r > NUM_MAG_W'(HUM_TOP)) begin
        res.scaled_value = 16'(HUM_TOP);
        res.status       = STATUS_CLAMP;
      end else begin
        res.scaled_value = quo_r[15:0];
      end
    end else if (neg_r) begin
      if (quo_r > NUM_MAG_W'(32768)) begin
        res.scaled_value = 16'sh8000;
        res.status       = STATUS_CLAMP;
      end else begin
        res.scaled_value = -quo_r[15:0];
      end
    end else begin
      if (quo_r > NUM_MAG_W'(32767)) begin
        res.scaled_value = 16'sh7fff;
        res.status       = STATUS_CLAMP;
      end else begin
        res.scaled_value = quo_r[15:0];
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_MAG_W);
      rem_nxt  = '0;
      quo_nxt  = job.num_mag;
    end else if (busy_r && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = fits ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
      quo_nxt = {quo_r[NUM_MAG_W-2:0], fits};
    end else if (finish) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
    if (take) begin
      act_r  <= job.action;
      neg_r  <= job.neg;
      zero_r <= job.zero;
      div_r  <= job.div_mag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/humidity_temp_calibrate.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_calibrate
// Path: three front stages, then the job queue, then the radix-2 divider
//   and its output register, from input beat to output beat.
// The divider takes one job at a time; later jobs wait in the queue and front.
// Reset: rst_n synchronous active low; clears all calibration registers to 0
//   and empties the pipeline, queue and output register.
// ----------------------------------------------------------------------------
module humidity_temp_calibrate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hcal_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hcal_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hcal_pkg::ADDR_W-1:0]   paddr,
  input  logic [hcal_pkg::DATA_W-1:0]   pwdata,
  output logic [hcal_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import hcal_pkg::*;

  hcal_cfg_t cfg_r, cfg_nxt;
  logic      wr_en;
  logic [2:0] reg_idx;

  logic      f_valid, f_ready;
  hcal_job_t f_job;
  logic      b_valid, b_ready;
  hcal_job_t b_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_TEMP_CAL_LOW:  cfg_nxt.temp_cal_low_x8  = pwdata[9:0];
        REG_TEMP_CAL_HIGH: cfg_nxt.temp_cal_high_x8 = pwdata[9:0];
        REG_TEMP_RAW_LOW:  cfg_nxt.temp_raw_low     = pwdata[15:0];
        REG_TEMP_RAW_HIGH: cfg_nxt.temp_raw_high    = pwdata[15:0];
        REG_HUM_CAL_LOW:   cfg_nxt.hum_cal_low_x2   = pwdata[7:0];
        REG_HUM_CAL_HIGH:  cfg_nxt.hum_cal_high_x2  = pwdata[7:0];
        REG_HUM_RAW_LOW:   cfg_nxt.hum_raw_low      = pwdata[15:0];
        REG_HUM_RAW_HIGH:  cfg_nxt.hum_raw_high     = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_CAL_LOW:  prdata = {22'd0, cfg_r.temp_cal_low_x8};
      REG_TEMP_CAL_HIGH: prdata = {22'd0, cfg_r.temp_cal_high_x8};
      REG_TEMP_RAW_LOW:  prdata = {16'd0, cfg_r.temp_raw_low};
      REG_TEMP_RAW_HIGH: prdata = {16'd0, cfg_r.temp_raw_high};
      REG_HUM_CAL_LOW:   prdata = {24'd0, cfg_r.hum_cal_low_x2};
      REG_HUM_CAL_HIGH:  prdata = {24'd0, cfg_r.hum_cal_high_x2};
      REG_HUM_RAW_LOW:   prdata = {16'd0, cfg_r.hum_raw_low};
      REG_HUM_RAW_HIGH:  prdata = {16'd0, cfg_r.hum_raw_high};
      default:           prdata = '0;
    endcase
  end

  hcal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  hcal_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_job)
  );

  hcal_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/hcal_checker.sv =====
// ----------------------------------------------------------------------------
// hcal_checker
// Port-level checks on the calibration block, bound to the top level.
// ----------------------------------------------------------------------------
module hcal_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input hcal_pkg::out_item_t           out_data
);
  import hcal_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_ZERO) |-> (out_data.scaled_value == 16'sd0))
    else $error("zero span result not zero");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_CLAMP) |->
      (out_data.scaled_value == 16'sd0) ||
      (out_data.scaled_value == 16'(HUM_TOP)) ||
      (out_data.scaled_value == 16'sh7fff) ||
      (out_data.scaled_value == 16'sh8000))
    else $error("clamped result not at a limit");

  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STATUS_OK) ||
                  (out_data.status == STATUS_CLAMP) ||
                  (out_data.status == STATUS_ZERO))
    else $error("undefined status code");

endmodule

bind humidity_temp_calibrate hcal_checker u_hcal_checker (.*);
